// ===== src/cpft_pkg.sv =====
// Shared types, constants and the sine table for the Clarke/Park forward transform.
package cpft_pkg;

    // Configuration of the datapath.
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SAMPLE_WIDTH     = 16;
    localparam int ANGLE_WIDTH      = 16;

    // Quarter-wave table: entries 0 .. SINE_TABLE_DEPTH inclusive.
    localparam int ROM_DEPTH = SINE_TABLE_DEPTH + 1;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int ROM_DW    = 15;
    localparam int SINE_W    = ROM_DW + 1;

    // Angle split: two quadrant bits and the fraction inside the quadrant.
    localparam int FRAC_W   = ANGLE_WIDTH - 2;
    localparam int KPROD_W  = FRAC_W + ROM_AW;

    // Clarke stage formats.
    localparam int GUARD_BITS     = 2;
    localparam int CLARKE_SHIFT   = 16 - GUARD_BITS;
    localparam int PARK_SHIFT     = 15 + GUARD_BITS;
    localparam int CONST_W        = 17;
    localparam int NUM_A_W        = SAMPLE_WIDTH + 2;
    localparam int NUM_B_W        = SAMPLE_WIDTH + 1;
    localparam int PROD_A_W       = NUM_A_W + CONST_W;
    localparam int PROD_B_W       = NUM_B_W + CONST_W;
    localparam int ALPHA_W        = SAMPLE_WIDTH + 3;

    // Park stage formats.
    localparam int PROD_W = ALPHA_W + SINE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RES_W  = SUM_W - PARK_SHIFT;

    localparam logic signed [CONST_W-1:0] ONE_THIRD_Q16 = 17'sd21845;
    localparam logic signed [CONST_W-1:0] INV_SQRT3_Q16 = 17'sd37837;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Taylor series constants used only while the table is elaborated.
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 9;
    localparam longint unsigned TAYLOR_DIV [1:TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342};

    typedef enum logic [1:0] {
        QUAD_FIRST  = 2'd0,
        QUAD_SECOND = 2'd1,
        QUAD_THIRD  = 2'd2,
        QUAD_FOURTH = 2'd3
    } t_quadrant;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] phase_a;
        logic signed [SAMPLE_WIDTH-1:0] phase_b;
        logic signed [SAMPLE_WIDTH-1:0] phase_c;
        logic        [ANGLE_WIDTH-1:0]  rotor_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] direct_current;
        logic signed [SAMPLE_WIDTH-1:0] quadrature_current;
        logic                           saturated;
    } t_out_item;

    typedef logic [ROM_DW-1:0] t_sine_rom [ROM_DEPTH];

    // One table entry: sin(pi/2 * k / depth) in Q15, built from a Q30 Taylor series.
    function automatic logic [ROM_DW-1:0] sine_entry(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        int              n;
        x    = (PI_HALF_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= TAYLOR_TERMS; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 32767) begin
            sum = 32767;
        end
        return sum[ROM_DW-1:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        int unsigned k;
        for (k = 0; k < ROM_DEPTH; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// ===== src/cpft_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module cpft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== src/clarke_park_forward_transform_top.sv =====
// Top level of the Clarke/Park forward transform pipeline.
//
// The input channel (i_valid, o_ready, i_item) takes one transaction with three signed
// phase currents and a rotor angle. The output channel (o_valid, i_ready, o_item) returns
// one transaction with the saturated d and q currents and a flag that is set when either
// of them was clipped. Items are independent; the block keeps no state between them.
//
// The datapath is a five-stage pipeline: input differences and table index, Clarke
// scaling together with the sine/cosine table read, quadrant fold and the four Park
// products, the d and q sums, and finally rounding and saturation into the output
// register. An accepted transaction moves through the stage registers in turn, and o_valid
// rises when it reaches the output register. Once the table is loaded and while the receiver
// takes every output, a new transaction can be accepted in every cycle, so throughput is one
// item per clock. That rate is set by the pipeline registers around the four Park multipliers
// and by the two read ports of the table memory, which serve sine and cosine together.
//
// After reset the quarter-wave table is copied into its memory, one entry per cycle;
// o_ready stays low after reset is released until that pass is finished. When the receiver
// holds i_ready low, the pipeline stages close up behind the output register and o_ready
// drops only once every stage is occupied.
module clarke_park_forward_transform_top
    import cpft_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    // ------------------------------------------------------------------
    // Table fill after reset
    // ------------------------------------------------------------------
    logic              r_fill_busy;
    logic              r_fill_done;
    logic [ROM_AW-1:0] r_fill_idx;
    logic              r_fill_we;
    logic [ROM_AW-1:0] r_fill_addr;
    logic [ROM_DW-1:0] r_fill_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_busy <= 1'b1;
            r_fill_done <= 1'b0;
            r_fill_idx  <= '0;
            r_fill_we   <= 1'b0;
        end else begin
            r_fill_we <= r_fill_busy;
            if (r_fill_busy) begin
                r_fill_idx <= r_fill_idx + ROM_AW'(1);
                if (r_fill_idx == ROM_AW'(ROM_DEPTH - 1)) begin
                    r_fill_busy <= 1'b0;
                end
            end
            // The last write lands in the same cycle that sets the done flag.
            if (r_fill_we && (r_fill_addr == ROM_AW'(ROM_DEPTH - 1))) begin
                r_fill_done <= 1'b1;
            end
        end
    end

    // Table data is staged through a register so the constant table read stays short.
    always_ff @(posedge i_clk) begin
        r_fill_addr <= r_fill_idx;
        r_fill_data <= SINE_ROM[r_fill_idx];
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or its
    // successor loads.
    // ------------------------------------------------------------------
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic r_out_valid;
    logic w_en1;
    logic w_en2;
    logic w_en3;
    logic w_en4;
    logic w_en5;
    logic w_accept;

    assign w_en5    = !r_out_valid || i_ready;
    assign w_en4    = !r_v4 || w_en5;
    assign w_en3    = !r_v3 || w_en4;
    assign w_en2    = !r_v2 || w_en3;
    assign w_en1    = !r_v1 || w_en2;
    assign o_ready  = r_fill_done && w_en1;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_accept;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
            if (w_en5) begin
                r_out_valid <= r_v4;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: Clarke numerators, quadrant and table index.
    // ------------------------------------------------------------------
    logic signed [NUM_A_W-1:0] w_a_ext;
    logic signed [NUM_A_W-1:0] w_b_ext;
    logic signed [NUM_A_W-1:0] w_c_ext;
    logic signed [NUM_B_W-1:0] w_b_nb;
    logic signed [NUM_B_W-1:0] w_c_nb;
    logic        [KPROD_W-1:0] w_k_prod;

    logic signed [NUM_A_W-1:0] r1_num_alpha;
    logic signed [NUM_B_W-1:0] r1_num_beta;
    t_quadrant                 r1_quad;
    logic        [ROM_AW-1:0]  r1_k;

    assign w_a_ext  = {{2{i_item.phase_a[SAMPLE_WIDTH-1]}}, i_item.phase_a};
    assign w_b_ext  = {{2{i_item.phase_b[SAMPLE_WIDTH-1]}}, i_item.phase_b};
    assign w_c_ext  = {{2{i_item.phase_c[SAMPLE_WIDTH-1]}}, i_item.phase_c};
    assign w_b_nb   = {i_item.phase_b[SAMPLE_WIDTH-1], i_item.phase_b};
    assign w_c_nb   = {i_item.phase_c[SAMPLE_WIDTH-1], i_item.phase_c};
    // Index inside the quadrant: fraction times table depth, truncated.
    assign w_k_prod = KPROD_W'(i_item.rotor_angle[FRAC_W-1:0]) * KPROD_W'(SINE_TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_num_alpha <= (w_a_ext <<< 1) - w_b_ext - w_c_ext;
            r1_num_beta  <= w_b_nb - w_c_nb;
            r1_quad      <= t_quadrant'(i_item.rotor_angle[ANGLE_WIDTH-1 -: 2]);
            r1_k         <= w_k_prod[KPROD_W-1 -: ROM_AW];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: Clarke scaling; sine and cosine read from the table.
    // ------------------------------------------------------------------
    logic signed [PROD_A_W-1:0] w_prod_alpha;
    logic signed [PROD_A_W-1:0] w_rnd_alpha;
    logic signed [PROD_B_W-1:0] w_prod_beta;
    logic signed [PROD_B_W-1:0] w_rnd_beta;
    logic        [ROM_AW-1:0]   w_cos_addr;
    logic        [ROM_DW-1:0]   w_rd_sin;
    logic        [ROM_DW-1:0]   w_rd_cos;

    logic signed [ALPHA_W-1:0]  r2_alpha;
    logic signed [ALPHA_W-1:0]  r2_beta;
    t_quadrant                  r2_quad;

    assign w_prod_alpha = r1_num_alpha * ONE_THIRD_Q16;
    assign w_prod_beta  = r1_num_beta * INV_SQRT3_Q16;
    assign w_rnd_alpha  = w_prod_alpha + PROD_A_W'(1 << (CLARKE_SHIFT - 1));
    assign w_rnd_beta   = w_prod_beta + PROD_B_W'(1 << (CLARKE_SHIFT - 1));
    assign w_cos_addr   = ROM_AW'(SINE_TABLE_DEPTH) - r1_k;

    cpft_ram #(
        .WIDTH (ROM_DW),
        .DEPTH (ROM_DEPTH)
    ) u_sine_ram (
        .i_clk     (i_clk),
        .i_we      (r_fill_we),
        .i_waddr   (r_fill_addr),
        .i_wdata   (r_fill_data),
        .i_re      (w_en2),
        .i_raddr_a (r1_k),
        .i_raddr_b (w_cos_addr),
        .o_rdata_a (w_rd_sin),
        .o_rdata_b (w_rd_cos)
    );

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_alpha <= ALPHA_W'(w_rnd_alpha >>> CLARKE_SHIFT);
            r2_beta  <= ALPHA_W'(w_rnd_beta >>> CLARKE_SHIFT);
            r2_quad  <= r1_quad;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quadrant fold and the four Park products.
    // ------------------------------------------------------------------
    logic signed [SINE_W-1:0] w_s0;
    logic signed [SINE_W-1:0] w_c0;
    logic signed [SINE_W-1:0] w_sn;
    logic signed [SINE_W-1:0] w_cs;

    logic signed [PROD_W-1:0] r3_p_ac;
    logic signed [PROD_W-1:0] r3_p_bs;
    logic signed [PROD_W-1:0] r3_p_bc;
    logic signed [PROD_W-1:0] r3_p_as;

    assign w_s0 = {1'b0, w_rd_sin};
    assign w_c0 = {1'b0, w_rd_cos};

    always_comb begin
        case (r2_quad)
            QUAD_FIRST: begin
                w_sn = w_s0;
                w_cs = w_c0;
            end
            QUAD_SECOND: begin
                w_sn = w_c0;
                w_cs = -w_s0;
            end
            QUAD_THIRD: begin
                w_sn = -w_s0;
                w_cs = -w_c0;
            end
            QUAD_FOURTH: begin
                w_sn = -w_c0;
                w_cs = w_s0;
            end
            default: begin
                w_sn = w_s0;
                w_cs = w_c0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_p_ac <= r2_alpha * w_cs;
            r3_p_bs <= r2_beta * w_sn;
            r3_p_bc <= r2_beta * w_cs;
            r3_p_as <= r2_alpha * w_sn;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: d and q sums.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] r4_d_sum;
    logic signed [SUM_W-1:0] r4_q_sum;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_d_sum <= SUM_W'(r3_p_ac) + SUM_W'(r3_p_bs);
            r4_q_sum <= SUM_W'(r3_p_bc) - SUM_W'(r3_p_as);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: round half up, saturate, output register.
    // ------------------------------------------------------------------
    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(SAMPLE_MAX);
    localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(SAMPLE_MIN);

    logic signed [SUM_W-1:0]        w_d_rnd;
    logic signed [SUM_W-1:0]        w_q_rnd;
    logic signed [RES_W-1:0]        w_d_res;
    logic signed [RES_W-1:0]        w_q_res;
    logic signed [SAMPLE_WIDTH-1:0] w_d_sat;
    logic signed [SAMPLE_WIDTH-1:0] w_q_sat;
    logic                           w_d_clip;
    logic                           w_q_clip;
    t_out_item                      r_out;

    assign w_d_rnd = r4_d_sum + SUM_W'(1 << (PARK_SHIFT - 1));
    assign w_q_rnd = r4_q_sum + SUM_W'(1 << (PARK_SHIFT - 1));
    assign w_d_res = RES_W'(w_d_rnd >>> PARK_SHIFT);
    assign w_q_res = RES_W'(w_q_rnd >>> PARK_SHIFT);

    always_comb begin
        w_d_clip = 1'b1;
        if (w_d_res > RES_MAX) begin
            w_d_sat = SAMPLE_MAX;
        end else if (w_d_res < RES_MIN) begin
            w_d_sat = SAMPLE_MIN;
        end else begin
            w_d_sat  = w_d_res[SAMPLE_WIDTH-1:0];
            w_d_clip = 1'b0;
        end
        w_q_clip = 1'b1;
        if (w_q_res > RES_MAX) begin
            w_q_sat = SAMPLE_MAX;
        end else if (w_q_res < RES_MIN) begin
            w_q_sat = SAMPLE_MIN;
        end else begin
            w_q_sat  = w_q_res[SAMPLE_WIDTH-1:0];
            w_q_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_out.direct_current     <= w_d_sat;
            r_out.quadrature_current <= w_q_sat;
            r_out.saturated          <= w_d_clip || w_q_clip;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_during_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fill_done |-> !o_ready)
        else $error("input ready while the sine table is still being loaded");

    a_fill_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_done |=> r_fill_done)
        else $error("table load flag dropped without reset");

    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_v1)
        else $error("accepted transaction did not enter the first stage");

    a_last_stage_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && w_en5) |=> r_out_valid)
        else $error("transaction lost between the sum stage and the output register");

    a_saturated_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.saturated) |->
            (r_out.direct_current == SAMPLE_MAX || r_out.direct_current == SAMPLE_MIN ||
             r_out.quadrature_current == SAMPLE_MAX ||
             r_out.quadrature_current == SAMPLE_MIN))
        else $error("saturation flag set while neither output sits at a limit");

endmodule
